FILE: sv/lpba_pkg.sv
`timescale 1ns / 1ps
package lpba_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 12;
    localparam int NUM_COEFFS     = 12;
    localparam int MAC_STEPS      = 9;

    localparam logic [4:0]  BOX_COUNT_RESET = 5'd0;
    localparam logic [9:0]  SHRINK_RESET    = 10'd100;
    localparam logic [9:0]  SHRINK_MAX      = 10'd999;
    localparam logic [22:0] RECIP_1000      = 23'd4294967;

    localparam logic REG_BOX_COUNT = 1'b0;
    localparam logic REG_SHRINK    = 1'b1;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_COEFF = 2'd1,
        OP_BOX   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_DIVSET,
        B_DIV,
        B_SCAN,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic [3:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [31:0] coeff;
        logic [11:0]        left;
        logic [11:0]        top;
        logic [11:0]        width;
        logic [11:0]        height;
    } t_req;

    typedef struct packed {
        logic [4:0] box_count;
        logic [9:0] shrink;
    } t_cfg;

    typedef struct packed {
        logic               assigned;
        logic [3:0]         box_index;
        logic [4:0]         count;
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic               behind;
    } t_res;

    // row-major coefficient index for each multiply step, column 3 excluded
    function automatic logic [3:0] mac_coef_idx(input logic [3:0] step);
        logic [3:0] r;
        case (step)
            4'd0: r = 4'd0;
            4'd1: r = 4'd1;
            4'd2: r = 4'd2;
            4'd3: r = 4'd4;
            4'd4: r = 4'd5;
            4'd5: r = 4'd6;
            4'd6: r = 4'd8;
            4'd7: r = 4'd9;
            4'd8: r = 4'd10;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/lpba_front.sv
`timescale 1ns / 1ps
module lpba_front
    import lpba_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_entry_index,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic signed [15:0] i_coord_z,
    input  logic signed [31:0] i_coeff_value,
    input  logic [11:0]        i_box_left,
    input  logic [11:0]        i_box_top,
    input  logic [11:0]        i_box_width,
    input  logic [11:0]        i_box_height,
    input  logic               i_q_full,
    output logic               o_push,
    output t_req               o_req
);

    logic c_keep;

    always_comb begin
        case (t_op'(i_operation))
            OP_POINT: c_keep = 1'b1;
            OP_COEFF: c_keep = (int'(i_entry_index) < NUM_COEFFS);
            OP_BOX:   c_keep = (int'(i_entry_index) < MAX_BOXES);
            default:  c_keep = 1'b0;
        endcase
    end

    always_comb begin
        o_req.op     = t_op'(i_operation);
        o_req.idx    = i_entry_index;
        o_req.x      = i_coord_x;
        o_req.y      = i_coord_y;
        o_req.z      = i_coord_z;
        o_req.coeff  = i_coeff_value;
        o_req.left   = i_box_left;
        o_req.top    = i_box_top;
        o_req.width  = i_box_width;
        o_req.height = i_box_height;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && c_keep;

endmodule

FILE: sv/lpba_queue.sv
`timescale 1ns / 1ps
module lpba_queue
    import lpba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_req o_req
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic c_push;
    logic c_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign c_push  = i_push && !o_full;
    assign c_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) r_wp <= ~r_wp;
            if (c_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(c_push) - 2'(c_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) r_mem[r_wp] <= i_req;
    end

endmodule

FILE: sv/lpba_back.sv
`timescale 1ns / 1ps
module lpba_back
    import lpba_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_req i_req,
    output logic o_pop,
    input  t_cfg i_cfg,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SB = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;

    t_bstate r_state;
    t_bstate n_state;

    logic signed [31:0] r_coef [NUM_COEFFS];
    logic [4*SB-1:0]    r_box_mem [MAX_BOXES];
    logic [4*SB-1:0]    r_rd;

    logic signed [15:0] r_x, r_y, r_z;
    logic [3:0]         r_step;
    logic [3:0]         r_pstep;
    logic signed [47:0] r_prod;
    logic signed [50:0] r_acc [3];

    logic [50:0] r_den;
    logic [50:0] r_rem0, r_rem1;
    logic [14:0] r_q0, r_q1;
    logic        r_sat0, r_sat1, r_neg0, r_neg1;
    logic [3:0]  r_dstep;

    logic [4:0]  r_issue;
    logic        r_issuing;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [4:0]  r_i1, r_i2, r_i3, r_i4;
    logic [11:0] r_l2, r_t2, r_w2, r_h2;
    logic [11:0] r_l3, r_t3, r_w3, r_h3;
    logic [11:0] r_l4, r_t4, r_w4, r_h4;
    logic [21:0] r_aw2, r_ah2, r_aw3, r_ah3;
    logic [44:0] r_pw3, r_ph3;
    logic [12:0] r_qw4, r_qh4;
    logic        r_rw4, r_rh4;

    logic [4:0]         r_cnt;
    logic [4:0]         r_hit;
    logic signed [15:0] r_u, r_v;
    logic               r_behind;

    logic       r_ovalid;
    t_res       r_res;

    logic       c_pop;
    logic       c_load;
    logic       c_scan_done;
    logic [4:0] c_nlim;
    logic [9:0] c_s;

    logic [3:0]         c_cidx;
    logic [3:0]         c_pidx;
    logic signed [15:0] c_crd;

    logic [65:0] c_dsh;
    logic [65:0] c_dfull;
    logic [50:0] c_mag0, c_mag1;

    logic signed [15:0] c_u, c_v;
    logic [14:0]        c_q0f, c_q1f;

    logic [12:0] c_qw0, c_qh0;
    logic [22:0] c_rw, c_rh;
    logic        c_rw_hi, c_rh_hi;

    logic [13:0]        c_l, c_t, c_le, c_te;
    logic signed [17:0] c_su, c_sv;
    logic               c_in;

    assign c_s    = (i_cfg.shrink > SHRINK_MAX) ? SHRINK_MAX : i_cfg.shrink;
    assign c_nlim = (int'(i_cfg.box_count) > MAX_BOXES) ? 5'(MAX_BOXES) : i_cfg.box_count;

    assign c_scan_done = !r_issuing && !r_v1 && !r_v2 && !r_v3 && !r_v4;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && i_req.op == OP_POINT) n_state = B_MAC;
            end
            B_MAC: begin
                if (r_step == 4'(MAC_STEPS)) n_state = B_DIVSET;
            end
            B_DIVSET: begin
                if (r_acc[2] <= 0) n_state = B_DONE;
                else n_state = B_DIV;
            end
            B_DIV: begin
                if (r_dstep == 4'd0) begin
                    n_state = (c_nlim == 5'd0) ? B_DONE : B_SCAN;
                end
            end
            B_SCAN: begin
                if (c_scan_done) n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_ovalid || !i_stall) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        c_pop  = 1'b0;
        c_load = 1'b0;
        case (r_state)
            B_IDLE: c_pop = i_q_valid;
            B_DONE: c_load = !r_ovalid || !i_stall;
            default: begin
                c_pop  = 1'b0;
                c_load = 1'b0;
            end
        endcase
    end

    assign o_pop = c_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else r_state <= n_state;
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (c_pop && i_req.op == OP_COEFF) r_coef[i_req.idx] <= i_req.coeff;
        if (c_pop && i_req.op == OP_BOX) begin
            r_box_mem[IW'(i_req.idx)] <= {i_req.left[SB-1:0], i_req.top[SB-1:0],
                                          i_req.width[SB-1:0], i_req.height[SB-1:0]};
        end
        r_rd <= r_box_mem[IW'(r_issue)];
    end

    // multiply-accumulate over the three rows
    assign c_cidx = mac_coef_idx(r_step);
    assign c_pidx = mac_coef_idx(r_pstep);

    always_comb begin
        case (c_cidx[1:0])
            2'd0:    c_crd = r_x;
            2'd1:    c_crd = r_y;
            default: c_crd = r_z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_pop && i_req.op == OP_POINT) begin
            r_x    <= i_req.x;
            r_y    <= i_req.y;
            r_z    <= i_req.z;
            r_step <= 4'd0;
            r_acc[0] <= {{11{r_coef[3][31]}}, r_coef[3], 8'd0};
            r_acc[1] <= {{11{r_coef[7][31]}}, r_coef[7], 8'd0};
            r_acc[2] <= {{11{r_coef[11][31]}}, r_coef[11], 8'd0};
        end else if (r_state == B_MAC) begin
            if (r_step != 4'(MAC_STEPS)) begin
                r_prod  <= r_coef[c_cidx] * c_crd;
                r_pstep <= r_step;
            end
            if (r_step != 4'd0) r_acc[c_pidx[3:2]] <= r_acc[c_pidx[3:2]] + 51'(r_prod);
            r_step <= r_step + 4'd1;
        end
    end

    // restoring divide of both numerators by the depth, fifteen quotient bits
    assign c_mag0  = r_acc[0][50] ? 51'(-r_acc[0]) : 51'(r_acc[0]);
    assign c_mag1  = r_acc[1][50] ? 51'(-r_acc[1]) : 51'(r_acc[1]);
    assign c_dfull = {r_acc[2][50:0], 15'd0};
    assign c_dsh   = {15'd0, r_den} << r_dstep;

    always_ff @(posedge i_clk) begin
        if (r_state == B_DIVSET) begin
            r_den    <= r_acc[2];
            r_rem0   <= c_mag0;
            r_rem1   <= c_mag1;
            r_neg0   <= r_acc[0][50];
            r_neg1   <= r_acc[1][50];
            r_sat0   <= {15'd0, c_mag0} >= c_dfull;
            r_sat1   <= {15'd0, c_mag1} >= c_dfull;
            r_q0     <= 15'd0;
            r_q1     <= 15'd0;
            r_dstep  <= 4'd14;
            r_behind <= (r_acc[2] <= 0);
        end else if (r_state == B_DIV) begin
            if ({15'd0, r_rem0} >= c_dsh) begin
                r_rem0 <= r_rem0 - c_dsh[50:0];
                r_q0   <= r_q0 | (15'd1 << r_dstep);
            end
            if ({15'd0, r_rem1} >= c_dsh) begin
                r_rem1 <= r_rem1 - c_dsh[50:0];
                r_q1   <= r_q1 | (15'd1 << r_dstep);
            end
            r_dstep <= r_dstep - 4'd1;
        end
    end

    assign c_q0f = r_q0 | 15'({15'd0, r_rem0} >= c_dsh);
    assign c_q1f = r_q1 | 15'({15'd0, r_rem1} >= c_dsh);

    always_comb begin
        if (r_sat0) c_u = r_neg0 ? 16'sh8000 : 16'sh7FFF;
        else c_u = r_neg0 ? -$signed({1'b0, c_q0f}) : $signed({1'b0, c_q0f});
        if (r_sat1) c_v = r_neg1 ? 16'sh8000 : 16'sh7FFF;
        else c_v = r_neg1 ? -$signed({1'b0, c_q1f}) : $signed({1'b0, c_q1f});
    end

    // box scan pipeline: read, shrink products, reciprocal, correct, compare
    assign c_qw0   = r_pw3[44:32];
    assign c_qh0   = r_ph3[44:32];
    assign c_rw    = 23'(r_aw3) - 23'(c_qw0) * 23'd1000;
    assign c_rh    = 23'(r_ah3) - 23'(c_qh0) * 23'd1000;
    assign c_rw_hi = (c_rw >= 23'd1000);
    assign c_rh_hi = (c_rh >= 23'd1000);

    assign c_l  = 14'(r_l4) + 14'(r_qw4[12:1]);
    assign c_t  = 14'(r_t4) + 14'(r_qh4[12:1]);
    assign c_le = c_l + 14'(r_w4) - 14'(r_qw4) - 14'(r_rw4);
    assign c_te = c_t + 14'(r_h4) - 14'(r_qh4) - 14'(r_rh4);
    assign c_su = 18'(r_u);
    assign c_sv = 18'(r_v);
    assign c_in = (c_su >= $signed({4'd0, c_l})) && (c_su < $signed({4'd0, c_le}))
               && (c_sv >= $signed({4'd0, c_t})) && (c_sv < $signed({4'd0, c_te}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
        end else begin
            if (r_state == B_DIV && r_dstep == 4'd0 && c_nlim != 5'd0) begin
                r_issuing <= 1'b1;
            end else if (r_issuing && r_issue == c_nlim - 5'd1) begin
                r_issuing <= 1'b0;
            end
            r_v1 <= r_issuing;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_DIV && r_dstep == 4'd0) begin
            r_issue <= 5'd0;
            r_cnt   <= 5'd0;
            r_hit   <= 5'd0;
            r_u     <= c_u;
            r_v     <= c_v;
        end else begin
            if (r_issuing) r_issue <= r_issue + 5'd1;
            if (r_v4 && c_in) begin
                if (r_cnt == 5'd0) r_hit <= r_i4;
                r_cnt <= r_cnt + 5'd1;
            end
        end
        if (r_state == B_DIVSET && r_acc[2] <= 0) begin
            r_u   <= 16'sd0;
            r_v   <= 16'sd0;
            r_cnt <= 5'd0;
            r_hit <= 5'd0;
        end
        r_i1 <= r_issue;
        r_l2 <= 12'(r_rd[4*SB-1:3*SB]);
        r_t2 <= 12'(r_rd[3*SB-1:2*SB]);
        r_w2 <= 12'(r_rd[2*SB-1:SB]);
        r_h2 <= 12'(r_rd[SB-1:0]);
        r_aw2 <= 22'(r_rd[2*SB-1:SB]) * 22'(c_s);
        r_ah2 <= 22'(r_rd[SB-1:0]) * 22'(c_s);
        r_i2 <= r_i1;
        r_l3 <= r_l2;
        r_t3 <= r_t2;
        r_w3 <= r_w2;
        r_h3 <= r_h2;
        r_aw3 <= r_aw2;
        r_ah3 <= r_ah2;
        r_pw3 <= 45'(r_aw2) * 45'(RECIP_1000);
        r_ph3 <= 45'(r_ah2) * 45'(RECIP_1000);
        r_i3 <= r_i2;
        r_l4 <= r_l3;
        r_t4 <= r_t3;
        r_w4 <= r_w3;
        r_h4 <= r_h3;
        r_qw4 <= c_qw0 + 13'(c_rw_hi);
        r_qh4 <= c_qh0 + 13'(c_rh_hi);
        r_rw4 <= c_rw_hi ? (c_rw != 23'd1000) : (c_rw != 23'd0);
        r_rh4 <= c_rh_hi ? (c_rh != 23'd1000) : (c_rh != 23'd0);
        r_i4 <= r_i3;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (c_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_res.assigned  <= (r_cnt == 5'd1);
            r_res.box_index <= (r_cnt == 5'd1) ? r_hit[3:0] : 4'd0;
            r_res.count     <= r_cnt;
            r_res.u         <= r_u;
            r_res.v         <= r_v;
            r_res.behind    <= r_behind;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

endmodule

FILE: sv/lidar_point_box_association.sv
`timescale 1ns / 1ps
// Projects each lidar point through a loaded 3x4 Q16.16 matrix, divides to a
// saturated pixel, and counts which of the first box_count shrunk boxes hold
// it. Coefficient and box writes are stored as the execution unit takes them
// from the queue. There a point is taken from the queue, put through the
// multiply-accumulate on a single 32x16 multiplier, then one setup step and
// fifteen restoring divide steps for u and v together; then one box per cycle,
// box_count capped at MAX_BOXES in all, enters a five-stage scan pipeline,
// which drains before the result is handed off. With no active boxes a point
// skips the scan; a point behind the camera skips the divide and
// the scan. A result held by a stalled receiver holds the
// execution unit. A two-entry request queue in front lets new requests enter
// while a point is in progress.
module lidar_point_box_association
    import lpba_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_entry_index,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic signed [15:0] i_coord_z,
    input  logic signed [31:0] i_coeff_value,
    input  logic [11:0]        i_box_left,
    input  logic [11:0]        i_box_top,
    input  logic [11:0]        i_box_width,
    input  logic [11:0]        i_box_height,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_assigned,
    output logic [3:0]         o_box_index,
    output logic [4:0]         o_enclosing_count,
    output logic signed [15:0] o_pixel_u,
    output logic signed [15:0] o_pixel_v,
    output logic               o_behind_camera,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg r_cfg;
    logic c_wr;

    logic c_push, c_full, c_qvalid, c_pop;
    t_req c_req_in, c_req_out;
    t_res c_res;

    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_count <= BOX_COUNT_RESET;
            r_cfg.shrink    <= SHRINK_RESET;
        end else if (c_wr) begin
            if (paddr[2] == REG_BOX_COUNT) r_cfg.box_count <= pwdata[4:0];
            else r_cfg.shrink <= pwdata[9:0];
        end
    end

    assign prdata = (paddr[2] == REG_SHRINK) ? 32'(r_cfg.shrink) : 32'(r_cfg.box_count);

    lpba_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_coeff_value (i_coeff_value),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_q_full      (c_full),
        .o_push        (c_push),
        .o_req         (c_req_in)
    );

    lpba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_req   (c_req_in),
        .o_full  (c_full),
        .o_valid (c_qvalid),
        .i_pop   (c_pop),
        .o_req   (c_req_out)
    );

    lpba_back #(.MAX_BOXES(MAX_BOXES), .PIXEL_BITS(PIXEL_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (c_qvalid),
        .i_req     (c_req_out),
        .o_pop     (c_pop),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (c_res)
    );

    assign o_assigned        = c_res.assigned;
    assign o_box_index       = c_res.box_index;
    assign o_enclosing_count = c_res.count;
    assign o_pixel_u         = c_res.u;
    assign o_pixel_v         = c_res.v;
    assign o_behind_camera   = c_res.behind;

endmodule

FILE: sv/lpba_checker.sv
`timescale 1ns / 1ps
module lpba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_assigned,
    input logic [3:0]         o_box_index,
    input logic [4:0]         o_enclosing_count,
    input logic signed [15:0] o_pixel_u,
    input logic signed [15:0] o_pixel_v,
    input logic               o_behind_camera
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_u) && $stable(o_pixel_v)
            && $stable(o_enclosing_count))
        else $error("stalled result changed");

    a_assign_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_assigned |-> o_enclosing_count == 5'd1 && !o_behind_camera)
        else $error("assigned without a single enclosing box");

    a_unassigned_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_assigned |-> o_box_index == 4'd0)
        else $error("slot reported for unassigned point");

    a_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_behind_camera |-> o_enclosing_count == 5'd0
            && o_pixel_u == 16'sd0 && o_pixel_v == 16'sd0)
        else $error("point behind camera carries a pixel or hits");

endmodule

bind lidar_point_box_association lpba_checker u_lpba_checker (.*);

FILE: tb/sv/tb_lidar_point_box_association.sv
`timescale 1ns / 1ps
module tb_lidar_point_box_association;
    import lpba_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [2:0] ADDR_BOXCOUNT = 3'd0;
    localparam logic [2:0] ADDR_SHRINK   = 3'd4;
    localparam int         IDLE_LIMIT    = 20000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 120;
    localparam int         ONE_Q16       = 65536;
    localparam int         PIX_SCALE     = 1 << 21;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_operation;
    logic [3:0]         i_entry_index;
    logic signed [15:0] i_coord_x;
    logic signed [15:0] i_coord_y;
    logic signed [15:0] i_coord_z;
    logic signed [31:0] i_coeff_value;
    logic [11:0]        i_box_left;
    logic [11:0]        i_box_top;
    logic [11:0]        i_box_width;
    logic [11:0]        i_box_height;
    logic               o_valid;
    logic               i_stall;
    logic               o_assigned;
    logic [3:0]         o_box_index;
    logic [4:0]         o_enclosing_count;
    logic signed [15:0] o_pixel_u;
    logic signed [15:0] o_pixel_v;
    logic               o_behind_camera;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lidar_point_box_association uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_entry_index(i_entry_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_coeff_value(i_coeff_value),
        .i_box_left(i_box_left), .i_box_top(i_box_top),
        .i_box_width(i_box_width), .i_box_height(i_box_height),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_assigned(o_assigned), .o_box_index(o_box_index),
        .o_enclosing_count(o_enclosing_count),
        .o_pixel_u(o_pixel_u), .o_pixel_v(o_pixel_v),
        .o_behind_camera(o_behind_camera),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    longint     coef_model [NUM_COEFFS];
    logic [11:0] box_l [MAX_BOXES_DEF];
    logic [11:0] box_t [MAX_BOXES_DEF];
    logic [11:0] box_w [MAX_BOXES_DEF];
    logic [11:0] box_h [MAX_BOXES_DEF];
    logic [4:0] cfg_box_count;
    logic [9:0] cfg_shrink;

    t_res       pending_results [$];
    int         mismatches;
    int         idle_cycles;
    bit         tx_quiet;
    bit         rx_quiet;
    int         hold_req;
    int         hold_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_res project_and_match(longint x, longint y, longint z);
        t_res   r;
        longint acc [3];
        longint u, v, s, w, h, l, t, ws, hs;
        int     n, cnt, hit;
        r = '0;
        for (int row = 0; row < 3; row++) begin
            acc[row] = coef_model[row*4] * x + coef_model[row*4+1] * y
                     + coef_model[row*4+2] * z + coef_model[row*4+3] * 256;
        end
        if (acc[2] <= 0) begin
            r.behind = 1'b1;
            return r;
        end
        u = acc[0] / acc[2];
        v = acc[1] / acc[2];
        if (u > 32767) u = 32767;
        if (u < -32768) u = -32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        s = (cfg_shrink > SHRINK_MAX) ? 999 : cfg_shrink;
        n = (cfg_box_count > MAX_BOXES_DEF) ? MAX_BOXES_DEF : cfg_box_count;
        cnt = 0;
        hit = 0;
        for (int i = 0; i < n; i++) begin
            w  = box_w[i];
            h  = box_h[i];
            l  = longint'(box_l[i]) + (w * s) / 2000;
            t  = longint'(box_t[i]) + (h * s) / 2000;
            ws = (w * (1000 - s)) / 1000;
            hs = (h * (1000 - s)) / 1000;
            if (u >= l && u < l + ws && v >= t && v < t + hs) begin
                if (cnt == 0) hit = i;
                cnt++;
            end
        end
        r.assigned  = (cnt == 1);
        r.box_index = (cnt == 1) ? hit[3:0] : 4'd0;
        r.count     = cnt[4:0];
        r.u         = u[15:0];
        r.v         = v[15:0];
        return r;
    endfunction

    task automatic record_request(input logic [1:0] op, input t_req q);
        case (op)
            OP_COEFF: if (q.idx < NUM_COEFFS) coef_model[q.idx] = longint'(q.coeff);
            OP_BOX: begin
                box_l[q.idx] = q.left;
                box_t[q.idx] = q.top;
                box_w[q.idx] = q.width;
                box_h[q.idx] = q.height;
            end
            OP_POINT: pending_results.insert(pending_results.size(),
                                             project_and_match(q.x, q.y, q.z));
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] op, input t_req q);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation   <= op;
        i_entry_index <= q.idx;
        i_coord_x     <= q.x;
        i_coord_y     <= q.y;
        i_coord_z     <= q.z;
        i_coeff_value <= q.coeff;
        i_box_left    <= q.left;
        i_box_top     <= q.top;
        i_box_width   <= q.width;
        i_box_height  <= q.height;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        record_request(op, q);
    endtask

    task automatic send_point(input int x, input int y, input int z);
        t_req q;
        q   = t_req'($urandom);
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        q.idx = 4'($urandom);
        send_request(OP_POINT, q);
    endtask

    task automatic send_coeff(input int idx, input int value);
        t_req q;
        q       = t_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
        q.idx   = 4'(idx);
        q.coeff = 32'(value);
        send_request(OP_COEFF, q);
    endtask

    task automatic send_box(input int slot, input int l, input int t, input int w,
                            input int h);
        t_req q;
        q        = t_req'({$urandom, $urandom, $urandom, $urandom});
        q.idx    = 4'(slot);
        q.left   = 12'(l);
        q.top    = 12'(t);
        q.width  = 12'(w);
        q.height = 12'(h);
        send_request(OP_BOX, q);
    endtask

    task automatic send_random_box(input int slot);
        send_box(slot, $urandom_range(0, 3800), $urandom_range(0, 3800),
                 $urandom_range(20, 1500), $urandom_range(20, 1500));
    endtask

    task automatic send_noise();
        t_req q;
        q = t_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 1)) send_request(OP_UNUSED, q);
        else send_coeff($urandom_range(12, 15), $urandom);
    endtask

    task automatic send_scene_point();
        if ($urandom_range(0, 9) == 0)
            send_point($urandom, $urandom, $urandom);
        else
            send_point($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BOXCOUNT) cfg_box_count = data[4:0];
        else cfg_shrink = data[9:0];
    endtask

    task automatic configure(input int count, input int shrink);
        drain();
        apb_write(ADDR_BOXCOUNT, {$urandom_range(0, 1) ? 27'h7FFFFFF : 27'h0, 5'(count)});
        apb_write(ADDR_SHRINK, {22'h0, 10'(shrink)});
    endtask

    task automatic load_pinhole(input bit jitter);
        for (int i = 0; i < NUM_COEFFS; i++) begin
            logic [31:0] c;
            c = 32'd0;
            if (i == 0 || i == 5) c = PIX_SCALE + (jitter ? $urandom_range(0, 1 << 18) : 0);
            if (jitter && (i == 2 || i == 6)) c = $urandom_range(0, 1 << 14) - (1 << 13);
            if (jitter && (i == 3 || i == 7)) c = $urandom_range(0, 1 << 22) - (1 << 21);
            if (jitter && i == 10) c = $urandom_range(0, 1 << 10);
            if (i == 11) c = ONE_Q16;
            send_coeff(i, c);
        end
    endtask

    task automatic test_load_tables();
        load_pinhole(1'b0);
        send_box(0, 100, 100, 200, 200);
        for (int i = 1; i < MAX_BOXES_DEF; i++) send_random_box(i);
        send_box(15, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_point(800, 800, 0);
    endtask

    task automatic test_directed();
        configure(1, 0);
        send_point(800, 800, 0);
        send_point(799, 800, 0);
        send_point(2399, 2399, 0);
        send_point(2400, 800, 0);
        send_point(800, 2400, 0);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h8000);
        configure(16, 999);
        send_point(1600, 1600, 0);
        send_point(0, 0, 0);
        send_coeff(0, 32'h7FFFFFFF);
        send_coeff(5, 32'h80000000);
        send_point(16'h7FFF, 16'h7FFF, 0);
        send_point(16'h8000, 16'h8000, 0);
        send_coeff(11, 32'd0);
        send_point(800, 800, 0);
        send_coeff(11, 32'hFFFF0000);
        send_point(800, 800, 0);
        send_coeff(12, 32'hFFFFFFFF);
        send_request(OP_UNUSED, t_req'({$urandom, $urandom, $urandom, $urandom}));
        load_pinhole(1'b0);
        send_point(800, 800, 0);
    endtask

    task automatic test_config_sweep();
        logic [4:0] counts [6] = '{5'd0, 5'd16, 5'd31, 5'd16, 5'd5, 5'd1};
        logic [9:0] shrinks [6] = '{10'd0, 10'd0, 10'd1023, 10'd999, 10'd500, 10'd100};
        for (int k = 0; k < 6; k++) begin
            configure(counts[k], shrinks[k]);
            rx_quiet = (k == 2);
            tx_quiet = (k == 2);
            for (int n = 0; n < 100; n++) send_scene_point();
        end
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int pick;
        configure(16, 100);
        load_pinhole(1'b1);
        for (int n = 0; n < 700; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) send_scene_point();
            else if (pick < 90) send_random_box($urandom_range(0, 15));
            else if (pick < 93) load_pinhole(1'b1);
            else if (pick < 95) send_coeff($urandom_range(0, 11), $urandom);
            else send_noise();
        end
        configure($urandom_range(0, 31), $urandom_range(0, 1023));
        for (int i = 0; i < NUM_COEFFS; i++) send_coeff(i, $urandom);
        for (int n = 0; n < 100; n++) send_point($urandom, $urandom, $urandom);
        load_pinhole(1'b1);
    endtask

    task automatic test_backpressure();
        configure(16, 50);
        hold_req++;
        tx_quiet = 1'b1;
        for (int n = 0; n < 40; n++) send_scene_point();
        tx_quiet = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_operation   <= OP_POINT;
        i_entry_index <= '0;
        i_coord_x     <= '0;
        i_coord_y     <= '0;
        i_coord_z     <= '0;
        i_coeff_value <= '0;
        i_box_left    <= '0;
        i_box_top     <= '0;
        i_box_width   <= '0;
        i_box_height  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cfg_box_count = BOX_COUNT_RESET;
        cfg_shrink    = SHRINK_RESET;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_req      = 0;
        for (int i = 0; i < NUM_COEFFS; i++) coef_model[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_load_tables();
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_traffic();
        drain();
        if (mismatches == 0) $display("tb_lidar_point_box_association: PASS");
        else $display("tb_lidar_point_box_association: FAIL");
        $finish;
    end

    initial begin
        int n;
        i_stall   <= 1'b0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (o_valid && !i_stall && !rx_quiet) begin
                n = $urandom_range(0, 5);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result u=%0d v=%0d", o_pixel_u, o_pixel_v);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_assigned !== exp_res.assigned) begin
                    $error("assigned: expected %0d, got %0d", exp_res.assigned, o_assigned);
                    mismatches++;
                end
                if (o_box_index !== exp_res.box_index) begin
                    $error("box_index: expected %0d, got %0d", exp_res.box_index, o_box_index);
                    mismatches++;
                end
                if (o_enclosing_count !== exp_res.count) begin
                    $error("enclosing_count: expected %0d, got %0d",
                           exp_res.count, o_enclosing_count);
                    mismatches++;
                end
                if (o_pixel_u !== exp_res.u) begin
                    $error("pixel_u: expected %0d, got %0d", exp_res.u, o_pixel_u);
                    mismatches++;
                end
                if (o_pixel_v !== exp_res.v) begin
                    $error("pixel_v: expected %0d, got %0d", exp_res.v, o_pixel_v);
                    mismatches++;
                end
                if (o_behind_camera !== exp_res.behind) begin
                    $error("behind_camera: expected %0d, got %0d",
                           exp_res.behind, o_behind_camera);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_lidar_point_box_association: FAIL");
                $finish;
            end
        end
    end

endmodule
